/* hw/rtl/arc_pkg.sv */
// arc_pkg: shared types, constants and helpers of the adaptive robust controller
// used by arc_ctrl, arc_dp and adaptive_robust_controller; depends on nothing
package arc_pkg;

   localparam int PW         = 66;   // wide product and accumulator width
   localparam int DIV_BITS   = 64;   // dividend magnitude bits, one per divide step
   localparam int DIV_CNT_W  = 6;
   localparam int PC_W       = 5;
   localparam int PROG_LAST  = 25;
   localparam int DT_SHIFT   = 17;   // trapezoid: half of Q0.16 interval

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_ERR,
      DP_MUL,
      DP_DIV_INIT,
      DP_DIV_STEP,
      DP_UA,
      DP_DRIVE,
      DP_T,
      DP_RATE,
      DP_PROJ,
      DP_INTEG
   } op_type;

   typedef enum logic [2:0] {
      M_P0Q,
      M_KE,
      M_QE,
      M_G0T,
      M_UAE,
      M_G1T,
      M_G2E,
      M_INT
   } mul_sel_type;

   typedef struct packed {
      op_type      op;
      mul_sel_type sel;
      logic [1:0]  idx;
   } cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] x);
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      hi = PW'(64'sh7fff_ffff);
      lo = -PW'(64'sh8000_0000);
      if (x > hi) begin
         return 32'sh7fff_ffff;
      end else if (x < lo) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   // micro-program of one item, one entry a cycle unless the drive step waits on an untaken result; divide step repeats
   function automatic cmd_type prog_step(input logic [PC_W-1:0] pc);
      cmd_type c;
      c = '{op: DP_NONE, sel: M_P0Q, idx: 2'd0};
      case (pc)
         5'd0:  c.op = DP_ERR;
         5'd1:  c = '{op: DP_MUL, sel: M_P0Q, idx: 2'd0};
         5'd2:  c.op = DP_DIV_INIT;
         5'd3:  c.op = DP_DIV_STEP;
         5'd4:  c.op = DP_UA;
         5'd5:  c = '{op: DP_MUL, sel: M_KE, idx: 2'd0};
         5'd6:  c.op = DP_DRIVE;
         5'd7:  c = '{op: DP_MUL, sel: M_QE, idx: 2'd0};
         5'd8:  c.op = DP_T;
         5'd9:  c = '{op: DP_MUL, sel: M_G0T, idx: 2'd0};
         5'd10: c = '{op: DP_RATE, sel: M_P0Q, idx: 2'd0};
         5'd11: c = '{op: DP_MUL, sel: M_UAE, idx: 2'd0};
         5'd12: c.op = DP_T;
         5'd13: c = '{op: DP_MUL, sel: M_G1T, idx: 2'd0};
         5'd14: c = '{op: DP_RATE, sel: M_P0Q, idx: 2'd1};
         5'd15: c = '{op: DP_MUL, sel: M_G2E, idx: 2'd0};
         5'd16: c = '{op: DP_RATE, sel: M_P0Q, idx: 2'd2};
         5'd17: c = '{op: DP_PROJ, sel: M_P0Q, idx: 2'd0};
         5'd18: c = '{op: DP_MUL, sel: M_INT, idx: 2'd0};
         5'd19: c = '{op: DP_INTEG, sel: M_P0Q, idx: 2'd0};
         5'd20: c = '{op: DP_PROJ, sel: M_P0Q, idx: 2'd1};
         5'd21: c = '{op: DP_MUL, sel: M_INT, idx: 2'd1};
         5'd22: c = '{op: DP_INTEG, sel: M_P0Q, idx: 2'd1};
         5'd23: c = '{op: DP_PROJ, sel: M_P0Q, idx: 2'd2};
         5'd24: c = '{op: DP_MUL, sel: M_INT, idx: 2'd2};
         5'd25: c = '{op: DP_INTEG, sel: M_P0Q, idx: 2'd2};
         default: c.op = DP_NONE;
      endcase
      return c;
   endfunction

endpackage

/* hw/rtl/adaptive_robust_controller.sv */
// channel   direction  handshake          payload
// req       in         req_valid/stall    measured_angle, desired_angle, desired_velocity,
//                                         step_interval
// rsp       out        rsp_valid/stall    drive
// csr       in         csr_valid/ready    csr_index, csr_data (gain registers)
//
// one item runs as a load beat, the bit-serial divider for the model term, and the rest
// of the program on the one shared 34x34 multiplier and adders
// the drive result is registered after the model term and may wait on rsp_stall while the
// item is still adapting; a new result that finds the old one untaken holds the sequence
// reset is synchronous and restores gains, parameters and previous rates; csr is always
// ready
module adaptive_robust_controller #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_measured_angle,
   input  logic signed [31:0] req_desired_angle,
   input  logic signed [31:0] req_desired_velocity,
   input  logic [15:0]        req_step_interval,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_drive,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   arc_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   arc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   arc_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_measured_angle   (req_measured_angle),
      .req_desired_angle    (req_desired_angle),
      .req_desired_velocity (req_desired_velocity),
      .req_step_interval    (req_step_interval),
      .csr_we               (csr_valid & csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .drive                (rsp_drive)
   );

   // an accepted beat keeps the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after accepted beat");

   // results only appear while an item is in flight
   a_result_in_flight: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall)
      else $error("result raised while idle");

   // a result is only raised where the previous one was already gone or taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> !$changed(rsp_drive))
      else $error("untaken result overwritten");

endmodule

/* hw/rtl/arc_ctrl.sv */
// arc_ctrl: sequencer of the adaptive robust controller, steps the micro-program
// depends on arc_pkg; drives arc_dp through arc_pkg::cmd_type
module arc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output arc_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

   state_type                          state_ff, state_in;
   logic [arc_pkg::PC_W-1:0]           pc_ff, pc_in;
   logic [arc_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   arc_pkg::cmd_type                   step;
   logic                               drive_blocked;
   logic                               advance;

   always_comb begin
      step          = arc_pkg::prog_step(pc_ff);
      drive_blocked = (step.op == arc_pkg::DP_DRIVE) && rsp_valid_ff && rsp_stall;
      cmd           = step;
      advance       = 1'b0;
      state_in      = state_ff;
      pc_in         = pc_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            cmd.op = req_valid ? arc_pkg::DP_LOAD : arc_pkg::DP_NONE;
            if (req_valid) begin
               state_in = S_RUN;
               pc_in    = '0;
            end
         end
         S_RUN: begin
            if (drive_blocked) begin
               cmd.op = arc_pkg::DP_NONE;
            end else begin
               advance = 1'b1;
               if (step.op == arc_pkg::DP_DRIVE) begin
                  rsp_valid_in = 1'b1;
               end
               // divide step stays until every quotient bit is done
               if (step.op == arc_pkg::DP_DIV_STEP) begin
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_ff != arc_pkg::DIV_CNT_W'(arc_pkg::DIV_BITS - 1)) begin
                     advance = 1'b0;
                  end
               end
            end
            if (advance) begin
               if (pc_ff == arc_pkg::PC_W'(arc_pkg::PROG_LAST)) begin
                  state_in = S_IDLE;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         default: begin
            cmd.op   = arc_pkg::DP_NONE;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/arc_dp.sv */
// arc_dp: datapath of the adaptive robust controller: shared multiplier, divider,
// parameter and rate stores, gain registers; depends on arc_pkg
module arc_dp #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  arc_pkg::cmd_type    cmd,
   input  logic signed [31:0]  req_measured_angle,
   input  logic signed [31:0]  req_desired_angle,
   input  logic signed [31:0]  req_desired_velocity,
   input  logic [15:0]         req_step_interval,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic signed [31:0]  drive
);

   localparam int PW = arc_pkg::PW;
   localparam longint ONE     = longint'(1) <<< FRAC_BITS;
   localparam longint LIM_HI0 = 400 * ONE;
   localparam longint LIM_HI1 = 100 * ONE;
   localparam longint LIM_HI2 = 300 * ONE;
   localparam longint LIM_LO0 = -150 * ONE;
   localparam longint LIM_LO1 = -100 * ONE;
   localparam longint LIM_LO2 = -3000 * ONE;
   localparam logic [31:0] K_RST  = 32'(ONE);
   localparam logic [31:0] G0_RST = 32'(20 * ONE);
   localparam logic [31:0] G1_RST = 32'((ONE + 500) / 1000);
   localparam logic [31:0] G2_RST = 32'(200 * ONE);
   localparam logic [31:0] P0_RST = 32'(-((808 * ONE + 5) / 10));
   localparam logic [31:0] P12_RST = 32'(20 * ONE);
   localparam logic [31:0] P1_FIX = 32'((ONE + 5) / 10);

   localparam logic [1:0] REG_K  = 2'd0;
   localparam logic [1:0] REG_G0 = 2'd1;
   localparam logic [1:0] REG_G1 = 2'd2;
   localparam logic [1:0] REG_G2 = 2'd3;

   logic [31:0]         k_ff, g0_ff, g1_ff, g2_ff;
   logic signed [31:0]  param_ff [3];
   logic signed [31:0]  prev_ff [3];
   logic signed [31:0]  rate_ff [3];
   logic signed [31:0]  q_ff, qd_ff, dqd_ff;
   logic [15:0]         dt_ff;
   logic signed [31:0]  e_ff, ua_ff, t_ff, drive_ff;
   logic signed [32:0]  rsum_ff;
   logic signed [PW-1:0] prod_ff;
   logic [31:0]         rem_ff;
   logic [arc_pkg::DIV_BITS-1:0] quo_ff;
   logic [31:0]         dvs_ff;
   logic                neg_ff;

   logic signed [33:0]  mul_a, mul_b;
   logic signed [67:0]  mul_full;
   logic signed [PW-1:0] shr_f, shr_dt;
   logic signed [32:0]  err_diff, pd;
   logic signed [PW-1:0] num;
   logic [PW-1:0]       num_abs;
   logic [32:0]         rem_sh;
   logic                rem_ge;
   logic [PW-1:0]       quo_x;
   logic signed [31:0]  p_sel, r_sel, pv_sel;
   longint              lim_hi, lim_lo;
   logic                clamp;
   logic signed [32:0]  rsum_new;
   logic signed [PW-1:0] integ_sum;

   always_comb begin
      case (cmd.sel)
         arc_pkg::M_P0Q: begin mul_a = 34'(param_ff[0]); mul_b = 34'(q_ff); end
         arc_pkg::M_KE:  begin mul_a = {2'b00, k_ff};    mul_b = 34'(e_ff); end
         arc_pkg::M_QE:  begin mul_a = 34'(q_ff);        mul_b = 34'(e_ff); end
         arc_pkg::M_G0T: begin mul_a = {2'b00, g0_ff};   mul_b = 34'(t_ff); end
         arc_pkg::M_UAE: begin mul_a = 34'(ua_ff);       mul_b = 34'(e_ff); end
         arc_pkg::M_G1T: begin mul_a = {2'b00, g1_ff};   mul_b = 34'(t_ff); end
         arc_pkg::M_G2E: begin mul_a = {2'b00, g2_ff};   mul_b = 34'(e_ff); end
         arc_pkg::M_INT: begin mul_a = 34'(rsum_ff); mul_b = {18'd0, dt_ff}; end
         default:        begin mul_a = '0;               mul_b = '0; end
      endcase
      mul_full = mul_a * mul_b;

      shr_f  = prod_ff >>> FRAC_BITS;
      shr_dt = prod_ff >>> arc_pkg::DT_SHIFT;

      err_diff = 33'(q_ff) - 33'(qd_ff);
      pd       = 33'(param_ff[2]) - 33'(dqd_ff);
      num      = prod_ff + (PW'(pd) <<< FRAC_BITS);
      num_abs  = num[PW-1] ? PW'(-num) : PW'(num);

      // restoring divide, one quotient bit a cycle
      rem_sh = {rem_ff, quo_ff[arc_pkg::DIV_BITS-1]};
      rem_ge = (rem_sh >= {1'b0, dvs_ff});
      quo_x  = {{(PW-arc_pkg::DIV_BITS){1'b0}}, quo_ff};

      case (cmd.idx)
         2'd0: begin
            p_sel = param_ff[0]; r_sel = rate_ff[0]; pv_sel = prev_ff[0];
            lim_hi = LIM_HI0; lim_lo = LIM_LO0;
         end
         2'd1: begin
            p_sel = param_ff[1]; r_sel = rate_ff[1]; pv_sel = prev_ff[1];
            lim_hi = LIM_HI1; lim_lo = LIM_LO1;
         end
         2'd2: begin
            p_sel = param_ff[2]; r_sel = rate_ff[2]; pv_sel = prev_ff[2];
            lim_hi = LIM_HI2; lim_lo = LIM_LO2;
         end
         default: begin
            p_sel = '0; r_sel = '0; pv_sel = '0;
            lim_hi = LIM_HI0; lim_lo = LIM_LO0;
         end
      endcase
      // projection at the fixed limits
      clamp = ((longint'(p_sel) >= lim_hi) && (r_sel > 0))
           || ((longint'(p_sel) <= lim_lo) && (r_sel < 0));
      rsum_new  = clamp ? 33'sd0 : (33'(r_sel) + 33'(pv_sel));
      integ_sum = PW'(p_sel) + shr_dt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= K_RST;
         g0_ff       <= G0_RST;
         g1_ff       <= G1_RST;
         g2_ff       <= G2_RST;
         param_ff[0] <= P0_RST;
         param_ff[1] <= P12_RST;
         param_ff[2] <= P12_RST;
         prev_ff[0]  <= '0;
         prev_ff[1]  <= '0;
         prev_ff[2]  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_K:   k_ff  <= {1'b0, csr_data[30:0]};
               REG_G0:  g0_ff <= {1'b0, csr_data[30:0]};
               REG_G1:  g1_ff <= {1'b0, csr_data[30:0]};
               REG_G2:  g2_ff <= {1'b0, csr_data[30:0]};
               default: ;
            endcase
         end
         case (cmd.op)
            arc_pkg::DP_LOAD: begin
               if (param_ff[1] == 32'sd0) begin
                  param_ff[1] <= P1_FIX;
               end
            end
            arc_pkg::DP_INTEG: begin
               case (cmd.idx)
                  2'd0: begin
                     param_ff[0] <= arc_pkg::sat32(integ_sum);
                     prev_ff[0]  <= rate_ff[0];
                  end
                  2'd1: begin
                     param_ff[1] <= arc_pkg::sat32(integ_sum);
                     prev_ff[1]  <= rate_ff[1];
                  end
                  2'd2: begin
                     param_ff[2] <= arc_pkg::sat32(integ_sum);
                     prev_ff[2]  <= rate_ff[2];
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         arc_pkg::DP_LOAD: begin
            q_ff   <= req_measured_angle;
            qd_ff  <= req_desired_angle;
            dqd_ff <= req_desired_velocity;
            dt_ff  <= req_step_interval;
         end
         arc_pkg::DP_ERR:  e_ff <= arc_pkg::sat32(PW'(err_diff));
         arc_pkg::DP_MUL:  prod_ff <= mul_full[PW-1:0];
         arc_pkg::DP_DIV_INIT: begin
            rem_ff <= '0;
            quo_ff <= num_abs[arc_pkg::DIV_BITS-1:0];
            dvs_ff <= param_ff[1][31] ? 32'(-param_ff[1]) : 32'(param_ff[1]);
            neg_ff <= num[PW-1] ^ param_ff[1][31];
         end
         arc_pkg::DP_DIV_STEP: begin
            rem_ff <= rem_ge ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
            quo_ff <= {quo_ff[arc_pkg::DIV_BITS-2:0], rem_ge};
         end
         // model term is minus the truncated quotient
         arc_pkg::DP_UA:    ua_ff <= arc_pkg::sat32(neg_ff ? quo_x : PW'(-quo_x));
         arc_pkg::DP_DRIVE: drive_ff <= arc_pkg::sat32(PW'(ua_ff) + shr_f);
         arc_pkg::DP_T:     t_ff <= arc_pkg::sat32(shr_f);
         arc_pkg::DP_RATE: begin
            case (cmd.idx)
               2'd0:    rate_ff[0] <= arc_pkg::sat32(shr_f);
               2'd1:    rate_ff[1] <= arc_pkg::sat32(shr_f);
               2'd2:    rate_ff[2] <= arc_pkg::sat32(shr_f);
               default: ;
            endcase
         end
         arc_pkg::DP_PROJ: begin
            rsum_ff <= rsum_new;
            case (cmd.idx)
               2'd0:    if (clamp) rate_ff[0] <= '0;
               2'd1:    if (clamp) rate_ff[1] <= '0;
               2'd2:    if (clamp) rate_ff[2] <= '0;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign drive = drive_ff;

endmodule
